/* rtl/core/fmrrc_pkg.sv */
// ----------------------------------------------------------------------------
// fmrrc_pkg
// Shared types, constants and helper functions of the first-move row
// run compressor.
// ----------------------------------------------------------------------------
package fmrrc_pkg;

    localparam int MASK_W    = 16;
    localparam int COORD_W   = 16;
    localparam int RUN_W     = 20;
    localparam int ARC_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Both internal queues share one geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    localparam logic [MASK_W-1:0] ALL_MOVES_RST = 16'd255;
    localparam logic [MASK_W-1:0] NO_MOVE_RST   = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_X  = 3'd0,
        CFG_SOURCE_Y  = 3'd1,
        CFG_HALF_SIDE = 3'd2,
        CFG_ALL_MOVES = 3'd3,
        CFG_NO_MOVE   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [MASK_W-1:0]  move_mask;
        logic [COORD_W-1:0] node_x;
        logic [COORD_W-1:0] node_y;
        logic               last_node;
    } t_in;

    typedef struct packed {
        logic [RUN_W-1:0] run_start;
        logic [ARC_W-1:0] first_arc;
        logic             row_end;
    } t_res;

    // A classified node waiting for the run stage.
    typedef struct packed {
        logic [MASK_W-1:0] eff_mask;
        logic              last;
    } t_mid;

    // Up to two results written to the result queue in one cycle.
    // wr1 is only ever set together with wr0.
    typedef struct packed {
        logic wr0;
        logic wr1;
        t_res res0;
        t_res res1;
    } t_out_wr;

    // Index of the lowest set bit; zero for an all-zero mask.
    function automatic logic [ARC_W-1:0] lowest_bit(input logic [MASK_W-1:0] m);
        logic [ARC_W-1:0] idx;
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = ARC_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/core/fmrrc_front.sv */
// ----------------------------------------------------------------------------
// fmrrc_front
// Configuration registers, node classification and the node queue that
// feeds the run stage.
// ----------------------------------------------------------------------------
module fmrrc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [fmrrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fmrrc_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                             i_push,
    input  fmrrc_pkg::t_in                   i_item,
    output logic                             o_full,
    input  logic                             i_mid_pop,
    output logic                             o_mid_empty,
    output fmrrc_pkg::t_mid                  o_mid_item
);

    logic [fmrrc_pkg::COORD_W-1:0] r_source_x;
    logic [fmrrc_pkg::COORD_W-1:0] r_source_y;
    logic [fmrrc_pkg::COORD_W-1:0] r_half_side;
    logic [fmrrc_pkg::MASK_W-1:0]  r_all_moves;
    logic [fmrrc_pkg::MASK_W-1:0]  r_no_move;

    fmrrc_pkg::t_mid               r_mem [fmrrc_pkg::QUEUE_DEPTH];
    logic [fmrrc_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [fmrrc_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [fmrrc_pkg::QUEUE_CW-1:0] r_count;
    logic [fmrrc_pkg::QUEUE_CW-1:0] n_count;

    logic [fmrrc_pkg::COORD_W-1:0] dist_x;
    logic [fmrrc_pkg::COORD_W-1:0] dist_y;
    logic                          in_square;
    fmrrc_pkg::t_mid               cls_item;
    logic                          push_ok;
    logic                          pop_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_x  <= '0;
            r_source_y  <= '0;
            r_half_side <= '0;
            r_all_moves <= fmrrc_pkg::ALL_MOVES_RST;
            r_no_move   <= fmrrc_pkg::NO_MOVE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fmrrc_pkg::CFG_SOURCE_X:  r_source_x  <= i_cfg_data;
                fmrrc_pkg::CFG_SOURCE_Y:  r_source_y  <= i_cfg_data;
                fmrrc_pkg::CFG_HALF_SIDE: r_half_side <= i_cfg_data;
                fmrrc_pkg::CFG_ALL_MOVES: r_all_moves <= i_cfg_data;
                fmrrc_pkg::CFG_NO_MOVE:   r_no_move   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Chebyshev distance test against the wildcard square.
    always_comb begin
        dist_x = (i_item.node_x >= r_source_x) ? i_item.node_x - r_source_x
                                               : r_source_x - i_item.node_x;
        dist_y = (i_item.node_y >= r_source_y) ? i_item.node_y - r_source_y
                                               : r_source_y - i_item.node_y;
        in_square = (dist_x <= r_half_side) && (dist_y <= r_half_side);

        if (in_square) begin
            cls_item.eff_mask = r_all_moves;
        end else if (i_item.move_mask == '0) begin
            cls_item.eff_mask = r_no_move;
        end else begin
            cls_item.eff_mask = i_item.move_mask;
        end
        cls_item.last = i_item.last_node;
    end

    assign o_full      = (r_count == fmrrc_pkg::QUEUE_CW'(fmrrc_pkg::QUEUE_DEPTH));
    assign o_mid_empty = (r_count == '0);
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_mid_pop && !o_mid_empty;
    assign o_mid_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (!push_ok && pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= cls_item;
        end
    end

endmodule

/* rtl/core/fmrrc_back.sv */
// ----------------------------------------------------------------------------
// fmrrc_back
// Run stage: folds classified nodes into the running mask and writes the
// finished runs to the result queue.
// ----------------------------------------------------------------------------
module fmrrc_back #(
    parameter int MAX_NODES = 1048576
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_mid_empty,
    input  fmrrc_pkg::t_mid       i_mid_item,
    output logic                  o_mid_pop,
    input  logic                  i_room,
    output fmrrc_pkg::t_out_wr    o_wr
);

    localparam int CW = $clog2(MAX_NODES);
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_NODES - 1);

    logic [CW-1:0]                r_node_count;
    logic [CW-1:0]                r_run_begin;
    logic [fmrrc_pkg::MASK_W-1:0] r_run_mask;
    logic                         r_row_started;

    logic                         take;
    logic [fmrrc_pkg::MASK_W-1:0] anded;
    logic                         brk;
    logic                         fresh;
    logic [fmrrc_pkg::MASK_W-1:0] new_mask;
    logic [CW-1:0]                new_begin;
    logic [CW-1:0]                inc_count;
    logic [CW+fmrrc_pkg::RUN_W-1:0] old_begin_ext;
    logic [CW+fmrrc_pkg::RUN_W-1:0] new_begin_ext;
    fmrrc_pkg::t_res              res_brk;
    fmrrc_pkg::t_res              res_end;

    always_comb begin
        take      = !i_mid_empty && i_room;
        anded     = r_run_mask & i_mid_item.eff_mask;
        brk       = r_row_started && (anded == '0);
        fresh     = !r_row_started || brk;
        new_mask  = fresh ? i_mid_item.eff_mask : anded;
        new_begin = fresh ? r_node_count : r_run_begin;
        inc_count = (r_node_count == LAST_IDX) ? '0 : r_node_count + 1'b1;

        old_begin_ext = {{fmrrc_pkg::RUN_W{1'b0}}, r_run_begin};
        new_begin_ext = {{fmrrc_pkg::RUN_W{1'b0}}, new_begin};

        res_brk.run_start = old_begin_ext[fmrrc_pkg::RUN_W-1:0];
        res_brk.first_arc = fmrrc_pkg::lowest_bit(r_run_mask);
        res_brk.row_end   = 1'b0;

        res_end.run_start = new_begin_ext[fmrrc_pkg::RUN_W-1:0];
        res_end.first_arc = fmrrc_pkg::lowest_bit(new_mask);
        res_end.row_end   = 1'b1;

        // A broken run goes out first; on the last node the closing run
        // follows it in the second slot.
        o_wr.wr0  = take && (brk || i_mid_item.last);
        o_wr.wr1  = take && brk && i_mid_item.last;
        o_wr.res0 = brk ? res_brk : res_end;
        o_wr.res1 = res_end;
    end

    assign o_mid_pop = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count  <= '0;
            r_run_begin   <= '0;
            r_run_mask    <= '0;
            r_row_started <= 1'b0;
        end else if (take) begin
            if (i_mid_item.last) begin
                r_node_count  <= '0;
                r_run_begin   <= '0;
                r_run_mask    <= '0;
                r_row_started <= 1'b0;
            end else begin
                r_node_count  <= inc_count;
                r_run_begin   <= new_begin;
                r_run_mask    <= new_mask;
                r_row_started <= 1'b1;
            end
        end
    end

endmodule

/* rtl/core/fmrrc_out_q.sv */
// ----------------------------------------------------------------------------
// fmrrc_out_q
// Result queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module fmrrc_out_q (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fmrrc_pkg::t_out_wr   i_wr,
    output logic                 o_room,
    input  logic                 i_pop,
    output logic                 o_empty,
    output fmrrc_pkg::t_res      o_res
);

    fmrrc_pkg::t_res                r_mem [fmrrc_pkg::QUEUE_DEPTH];
    logic [fmrrc_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [fmrrc_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [fmrrc_pkg::QUEUE_CW-1:0] r_count;
    logic [fmrrc_pkg::QUEUE_CW-1:0] n_count;
    logic [fmrrc_pkg::QUEUE_AW-1:0] wr_ptr_1;
    logic                           pop_ok;

    assign o_empty  = (r_count == '0);
    assign o_room   = (r_count <= fmrrc_pkg::QUEUE_CW'(fmrrc_pkg::QUEUE_DEPTH - 2));
    assign pop_ok   = i_pop && !o_empty;
    assign o_res    = r_mem[r_rd_ptr];
    assign wr_ptr_1 = r_wr_ptr + 1'b1;

    always_comb begin
        n_count = r_count
                + {{(fmrrc_pkg::QUEUE_CW-1){1'b0}}, i_wr.wr0}
                + {{(fmrrc_pkg::QUEUE_CW-1){1'b0}}, i_wr.wr1}
                - {{(fmrrc_pkg::QUEUE_CW-1){1'b0}}, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr.wr1) begin
                r_wr_ptr <= r_wr_ptr + 2'd2;
            end else if (i_wr.wr0) begin
                r_wr_ptr <= wr_ptr_1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr0) begin
            r_mem[r_wr_ptr] <= i_wr.res0;
        end
        if (i_wr.wr1) begin
            r_mem[wr_ptr_1] <= i_wr.res1;
        end
    end

endmodule

/* rtl/core/first_move_row_run_compressor.sv */
// ----------------------------------------------------------------------------
// first_move_row_run_compressor
// Run-length compressor for one row of a first-move table.
// ----------------------------------------------------------------------------
// Nodes of a row are pushed in index order, one per cycle unless full, each
// with its move mask, grid coordinates and a last-node flag. The front stage
// substitutes the wildcard mask for nodes inside the square around the source
// and the no-move mask for nodes with an empty mask, then writes the node into
// a four-entry queue in the same cycle it is accepted. The run stage takes one
// node per cycle from that queue whenever the four-entry result queue has room
// for two results. Each node is registered in the node queue, and its results
// in the result queue, before they are read. A node that breaks the
// running AND produces one result, and the last node of a row produces one
// or, when it also breaks the run, two; the result side drains one result per
// cycle, which sets the long-term rate when many runs are short. After the
// last node the row state clears, so the next node opens a new row at index
// zero. Configuration transactions are always taken (ready is tied high) and
// must only be issued while the block holds no pending node or result.
// ----------------------------------------------------------------------------
module first_move_row_run_compressor #(
    parameter int MAX_NODES = 1048576
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fmrrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fmrrc_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    // Node input, queue style.
    input  logic                             push,
    output logic                             full,
    input  fmrrc_pkg::t_in                   i_item,
    // Result output, queue style.
    output logic                             empty,
    input  logic                             pop,
    output fmrrc_pkg::t_res                  o_result
);

    logic                 mid_empty;
    logic                 mid_pop;
    fmrrc_pkg::t_mid      mid_item;
    logic                 out_room;
    fmrrc_pkg::t_out_wr   out_wr;

    // Register writes are always accepted.
    assign o_cfg_ready = 1'b1;

    fmrrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_mid_pop   (mid_pop),
        .o_mid_empty (mid_empty),
        .o_mid_item  (mid_item)
    );

    fmrrc_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty),
        .i_mid_item  (mid_item),
        .o_mid_pop   (mid_pop),
        .i_room      (out_room),
        .o_wr        (out_wr)
    );

    fmrrc_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (out_wr),
        .o_room  (out_room),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (o_result)
    );

endmodule
